// ===== rtl/flv_stream_tag_parser_defines.svh =====
// Assertion macros shared by the parser RTL.
// Each macro takes a label, a clock, a synchronous reset, an antecedent and a consequent.
`ifndef FLV_STREAM_TAG_PARSER_DEFINES_SVH
`define FLV_STREAM_TAG_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
`define FLVTP_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("flvtp: same-cycle check failed");
`define FLVTP_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("flvtp: next-cycle check failed");
`else
`define FLVTP_ASSERT_NOW(lbl, ck, rs, ante, cons)
`define FLVTP_ASSERT_NEXT(lbl, ck, rs, ante, cons)
`endif

`endif

// ===== rtl/flvtp_pkg.sv =====
`default_nettype none
package flvtp_pkg;

  // Record kinds.
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_TAG    = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_SIGNATURE = 2'd1;
  localparam logic [1:0] ST_LIMIT     = 2'd2;
  localparam logic [1:0] ST_UNKNOWN   = 2'd3;

  // Tag types.
  localparam logic [7:0] TAG_AUDIO  = 8'd8;
  localparam logic [7:0] TAG_VIDEO  = 8'd9;
  localparam logic [7:0] TAG_SCRIPT = 8'd18;

  // Fixed segment lengths.
  localparam logic [24:0] LEN_HEADER = 25'd9;
  localparam logic [24:0] LEN_WORD   = 25'd4;
  localparam logic [24:0] LEN_TAGHDR = 25'd11;

  localparam logic [31:0] LIMIT_RESET = 32'd16777216;

  typedef struct packed {
    logic [1:0]  record_kind;
    logic [1:0]  status;
    logic [7:0]  tag_type;
    logic [23:0] data_size;
    logic [31:0] timestamp;
    logic [23:0] stream_id;
    logic [31:0] prev_tag_size;
    logic [3:0]  media_high;
    logic [3:0]  media_low;
    logic [23:0] composition_time;
    logic [31:0] pts;
  } record_t;

  // Signature bytes "F", "L", "V".
  function automatic logic [7:0] sig_byte(input logic [1:0] pos);
    logic [7:0] val;
    case (pos)
      2'd0:    val = 8'h46;
      2'd1:    val = 8'h4C;
      default: val = 8'h56;
    endcase
    return val;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/flv_stream_tag_parser.sv =====
// Channel   Direction  Handshake            Payload
// -------   ---------  ---------            -------
// input     in         in_valid/in_ready    data_byte, end_of_stream
// result    out        out_valid/out_ready  record_kind ... pts (one port per field)
// config    in         cfg_write_en         cfg_write_data (buffer_limit)
//
// One transaction is accepted per cycle when the result side keeps up; the parse state
// advances one byte per cycle under the same condition, in a single combinational pass
// between the input register and the result register, so each input transaction is held
// in the input register and its result is then registered in the result register.
// Reset (rst, synchronous) returns the parser to waiting for a file header, clears the
// halt flag and loads buffer_limit with 16777216.
// A stalled result register holds the input register, which in turn drops in_ready.
// After an error record the block swallows every input transaction until reset.
`default_nettype none
`include "flv_stream_tag_parser_defines.svh"
module flv_stream_tag_parser
  import flvtp_pkg::*;
(
  input  wire               clk,
  input  wire               rst,
  input  wire               cfg_write_en,
  input  wire        [31:0] cfg_write_data,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire         [7:0] data_byte,
  input  wire               end_of_stream,
  output logic              out_valid,
  input  wire               out_ready,
  output logic        [1:0] record_kind,
  output logic        [1:0] status,
  output logic        [7:0] tag_type,
  output logic       [23:0] data_size,
  output logic       [31:0] timestamp,
  output logic       [23:0] stream_id,
  output logic       [31:0] prev_tag_size,
  output logic        [3:0] media_high,
  output logic        [3:0] media_low,
  output logic signed [23:0] composition_time,
  output logic       [31:0] pts
);

  // Parser phases.
  localparam logic [2:0] PH_HEADER     = 3'd0;
  localparam logic [2:0] PH_FIRST_PREV = 3'd1;
  localparam logic [2:0] PH_TAG_HDR    = 3'd2;
  localparam logic [2:0] PH_PAYLOAD    = 3'd3;
  localparam logic [2:0] PH_TRAIL      = 3'd4;

  logic [31:0] buffer_limit;

  // Input register.
  logic       a_valid;
  logic [7:0] a_byte;
  logic       a_end;
  logic       a_fire;

  // Parse state.
  logic [2:0]  phase, phase_next;
  logic [23:0] seg, seg_next;
  logic [31:0] consumed, consumed_next;
  logic [7:0]  kept_type, kept_type_next;
  logic [23:0] kept_size, kept_size_next;
  logic [31:0] kept_time, kept_time_next;
  logic [23:0] kept_stream, kept_stream_next;
  logic [31:0] kept_word, kept_word_next;
  logic [7:0]  kept_media, kept_media_next;
  logic [31:0] kept_offset, kept_offset_next;
  logic [23:0] comp_bits, comp_bits_next;
  logic        sig_ok, sig_ok_next;
  logic        halted, halted_next;

  // Result register.
  record_t res, res_next;
  logic    emit;

  // Limit check: one shared adder for the segment start and the payload check.
  logic [24:0] seg_len;
  logic        seg_start;
  logic        hdr_last;
  logic [24:0] add_b;
  logic [32:0] limit_sum;
  logic        limit_hit;
  logic        type_known;
  logic [23:0] comp_shift;

  assign a_fire   = a_valid && (!out_valid || out_ready);
  assign in_ready = !a_valid || a_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_limit <= LIMIT_RESET;
    end else if (cfg_write_en) begin
      buffer_limit <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      a_valid <= 1'b1;
    end else if (a_fire) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_byte <= data_byte;
      a_end  <= end_of_stream;
    end
  end

  always_comb begin
    unique case (phase) inside
      PH_HEADER:               seg_len = LEN_HEADER;
      PH_FIRST_PREV, PH_TRAIL: seg_len = LEN_WORD;
      PH_TAG_HDR:              seg_len = LEN_TAGHDR;
      default:                 seg_len = '0;
    endcase
  end

  assign seg_start  = (seg == 24'd0) && (seg_len != 25'd0);
  assign hdr_last   = (phase == PH_TAG_HDR) && (seg == 24'd10);
  // At the last tag header byte the count has not yet taken that byte, hence size + 1.
  assign add_b      = hdr_last ? ({1'b0, kept_size} + 25'd1) : seg_len;
  assign limit_sum  = {1'b0, consumed} + {8'b0, add_b};
  assign limit_hit  = limit_sum >= {1'b0, buffer_limit};
  assign type_known = (kept_type == TAG_AUDIO) || (kept_type == TAG_VIDEO) ||
                      (kept_type == TAG_SCRIPT);

  always_comb begin
    phase_next       = phase;
    seg_next         = seg;
    consumed_next    = consumed;
    kept_type_next   = kept_type;
    kept_size_next   = kept_size;
    kept_time_next   = kept_time;
    kept_stream_next = kept_stream;
    kept_word_next   = kept_word;
    kept_media_next  = kept_media;
    kept_offset_next = kept_offset;
    comp_bits_next   = comp_bits;
    sig_ok_next      = sig_ok;
    halted_next      = halted;
    res_next         = '0;
    emit             = 1'b0;
    comp_shift       = comp_bits;

    if (a_fire && !halted) begin
      if (a_end) begin
        // An end transaction drops any partial header or tag.
        phase_next    = PH_HEADER;
        seg_next      = '0;
        consumed_next = '0;
        sig_ok_next   = 1'b1;
        emit          = 1'b1;
        res_next.record_kind = KIND_END;
        res_next.status      = ST_OK;
      end else if (seg_start && limit_hit) begin
        halted_next          = 1'b1;
        emit                 = 1'b1;
        res_next.record_kind = KIND_ERROR;
        res_next.status      = ST_LIMIT;
      end else begin
        seg_next      = seg + 24'd1;
        consumed_next = consumed + 32'd1;
        unique case (phase)
          PH_HEADER: begin
            if (seg < 24'd3) begin
              if (a_byte != sig_byte(seg[1:0])) begin
                sig_ok_next = 1'b0;
              end
            end else if (seg == 24'd3) begin
              kept_type_next = a_byte;
            end else if (seg == 24'd4) begin
              kept_media_next = a_byte;
            end else begin
              kept_offset_next = {kept_offset[23:0], a_byte};
            end
            if (seg == 24'd8) begin
              if (!sig_ok) begin
                halted_next          = 1'b1;
                emit                 = 1'b1;
                res_next.record_kind = KIND_ERROR;
                res_next.status      = ST_SIGNATURE;
              end else begin
                phase_next = PH_FIRST_PREV;
                seg_next   = '0;
              end
            end
          end
          PH_FIRST_PREV: begin
            kept_word_next = {kept_word[23:0], a_byte};
            if (seg == 24'd3) begin
              phase_next             = PH_TAG_HDR;
              seg_next               = '0;
              emit                   = 1'b1;
              res_next.record_kind   = KIND_HEADER;
              res_next.tag_type      = kept_type;
              res_next.timestamp     = kept_offset;
              res_next.prev_tag_size = kept_word_next;
              res_next.media_high    = kept_media[7:4];
              res_next.media_low     = kept_media[3:0];
            end
          end
          PH_TAG_HDR: begin
            if (seg == 24'd0) begin
              kept_type_next   = a_byte;
              kept_media_next  = '0;
              comp_bits_next   = '0;
              kept_size_next   = '0;
              kept_time_next   = '0;
              kept_stream_next = '0;
            end else if (seg <= 24'd3) begin
              kept_size_next = {kept_size[15:0], a_byte};
            end else if (seg <= 24'd6) begin
              kept_time_next = {8'd0, kept_time[15:0], a_byte};
            end else if (seg == 24'd7) begin
              kept_time_next = {a_byte, kept_time[23:0]};
            end else begin
              kept_stream_next = {kept_stream[15:0], a_byte};
            end
            if (hdr_last) begin
              seg_next = '0;
              if (limit_hit) begin
                halted_next          = 1'b1;
                emit                 = 1'b1;
                res_next.record_kind = KIND_ERROR;
                res_next.status      = ST_LIMIT;
              end else if (kept_size != 24'd0) begin
                phase_next = PH_PAYLOAD;
              end else if (!type_known) begin
                halted_next          = 1'b1;
                emit                 = 1'b1;
                res_next.record_kind = KIND_ERROR;
                res_next.status      = ST_UNKNOWN;
              end else begin
                phase_next = PH_TRAIL;
              end
            end
          end
          PH_PAYLOAD: begin
            if (seg == 24'd0) begin
              kept_media_next = a_byte;
            end else if (seg >= 24'd2 && seg <= 24'd4) begin
              comp_bits_next = {comp_bits[15:0], a_byte};
            end
            if (({1'b0, seg} + 25'd1) >= {1'b0, kept_size}) begin
              // A short payload carries only the leading composition bytes; the
              // missing low bytes read as zero.
              comp_shift = comp_bits_next;
              if (kept_size == 24'd3) begin
                comp_shift = {comp_bits_next[7:0], 16'd0};
              end else if (kept_size == 24'd4) begin
                comp_shift = {comp_bits_next[15:0], 8'd0};
              end
              comp_bits_next = comp_shift;
              seg_next       = '0;
              if (!type_known) begin
                halted_next          = 1'b1;
                emit                 = 1'b1;
                res_next.record_kind = KIND_ERROR;
                res_next.status      = ST_UNKNOWN;
              end else begin
                phase_next = PH_TRAIL;
              end
            end
          end
          PH_TRAIL: begin
            kept_word_next = {kept_word[23:0], a_byte};
            if (seg == 24'd3) begin
              phase_next             = PH_TAG_HDR;
              seg_next               = '0;
              emit                   = 1'b1;
              res_next.record_kind   = KIND_TAG;
              res_next.tag_type      = kept_type;
              res_next.data_size     = kept_size;
              res_next.timestamp     = kept_time;
              res_next.stream_id     = kept_stream;
              res_next.prev_tag_size = kept_word_next;
              res_next.media_high    = kept_media[7:4];
              res_next.media_low     = kept_media[3:0];
              if (kept_type == TAG_VIDEO) begin
                res_next.composition_time = comp_bits;
                res_next.pts = kept_time + {{8{comp_bits[23]}}, comp_bits};
              end
            end
          end
          default: begin
            phase_next    = PH_HEADER;
            seg_next      = '0;
            consumed_next = '0;
            sig_ok_next   = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_HEADER;
      seg      <= '0;
      consumed <= '0;
      sig_ok   <= 1'b1;
      halted   <= 1'b0;
    end else begin
      phase    <= phase_next;
      seg      <= seg_next;
      consumed <= consumed_next;
      sig_ok   <= sig_ok_next;
      halted   <= halted_next;
    end
  end

  // Every kept field is loaded before it is read, so none needs a reset.
  always_ff @(posedge clk) begin
    kept_type   <= kept_type_next;
    kept_size   <= kept_size_next;
    kept_time   <= kept_time_next;
    kept_stream <= kept_stream_next;
    kept_word   <= kept_word_next;
    kept_media  <= kept_media_next;
    kept_offset <= kept_offset_next;
    comp_bits   <= comp_bits_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (a_fire && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_fire && emit) begin
      res <= res_next;
    end
  end

  assign record_kind      = res.record_kind;
  assign status           = res.status;
  assign tag_type         = res.tag_type;
  assign data_size        = res.data_size;
  assign timestamp        = res.timestamp;
  assign stream_id        = res.stream_id;
  assign prev_tag_size    = res.prev_tag_size;
  assign media_high       = res.media_high;
  assign media_low        = res.media_low;
  assign composition_time = res.composition_time;
  assign pts              = res.pts;

  // Once halted and drained, the block must never present another record.
  `FLVTP_ASSERT_NEXT(a_halt_silent, clk, rst, halted && !out_valid, !out_valid)
  // An error record is always paired with the halt flag.
  `FLVTP_ASSERT_NOW(a_error_halts, clk, rst, out_valid && record_kind == KIND_ERROR, halted)
  // An end transaction on a live parser yields an end record next cycle.
  `FLVTP_ASSERT_NEXT(a_end_record, clk, rst, a_fire && a_end && !halted,
                     out_valid && record_kind == KIND_END && phase == PH_HEADER)
  // Only video tags carry a composition time or pts.
  `FLVTP_ASSERT_NOW(a_pts_video, clk, rst,
                    out_valid && record_kind == KIND_TAG && tag_type != TAG_VIDEO,
                    pts == 32'd0 && composition_time == 24'sd0)

endmodule
`default_nettype wire

// ===== test/flv_stream_tag_parser_tb.sv =====
`timescale 1ns / 100ps

module flv_stream_tag_parser_tb
  import flvtp_pkg::*;
;

  // The run is ended as a failure if it has not finished after this many clock cycles.
  localparam int RUN_CYCLE_LIMIT = 400000;
  // Cycles allowed after the last expected record for the two-stage pipeline to drain.
  localparam int SETTLE_CYCLES = 8;

  localparam logic [23:0] FLV_MAGIC = 24'h464C56;

  // Receiver behavior during one stretch of cycles.
  localparam int RX_OPEN   = 0;
  localparam int RX_CHOPPY = 1;
  localparam int RX_CHOKED = 2;

  // The error that closes the run. An error halts the parser until reset, and reset is
  // applied only once, so exactly one of these is exercised per seed.
  localparam int FE_SIGNATURE  = 0;
  localparam int FE_TAG_TYPE   = 1;
  localparam int FE_LIMIT_ZERO = 2;
  localparam int FE_LIMIT_EDGE = 3;
  localparam int FE_OVERSIZE   = 4;

  typedef enum logic [2:0] {
    PS_HEADER,
    PS_FIRST_WORD,
    PS_TAG_HEADER,
    PS_PAYLOAD,
    PS_TRAILER
  } parse_phase_t;

  // One input transaction: a stream byte, or an end-of-stream marker.
  typedef struct packed {
    logic       eos;
    logic [7:0] data;
  } stream_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write_en = 1'b0;
  logic [31:0] cfg_write_data = 32'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic  [7:0] data_byte = 8'd0;
  logic        end_of_stream = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic  [1:0] record_kind;
  logic  [1:0] status;
  logic  [7:0] tag_type;
  logic [23:0] data_size;
  logic [31:0] timestamp;
  logic [23:0] stream_id;
  logic [31:0] prev_tag_size;
  logic  [3:0] media_high;
  logic  [3:0] media_low;
  logic signed [23:0] composition_time;
  logic [31:0] pts;

  flv_stream_tag_parser DUT (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_en     (cfg_write_en),
    .cfg_write_data   (cfg_write_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .data_byte        (data_byte),
    .end_of_stream    (end_of_stream),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .record_kind      (record_kind),
    .status           (status),
    .tag_type         (tag_type),
    .data_size        (data_size),
    .timestamp        (timestamp),
    .stream_id        (stream_id),
    .prev_tag_size    (prev_tag_size),
    .media_high       (media_high),
    .media_low        (media_low),
    .composition_time (composition_time),
    .pts              (pts)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Items still to be driven, and items built for the next phase but held back until the
  // buffer limit for that phase has been written.
  stream_item_t stream_items[$];
  stream_item_t staged_items[$];
  // Records the parser owes us, oldest first.
  record_t      records_due[$];

  int mismatches = 0;
  int cycle_count = 0;

  // ---------------------------------------------------------------------------------
  // Parser state as the testbench tracks it. It advances once per accepted input
  // transaction and is the sole source of expected records.
  // ---------------------------------------------------------------------------------
  logic [31:0]  byte_limit;
  parse_phase_t parse_phase;
  logic [23:0]  seg_count;
  logic [31:0]  fed_bytes;
  logic  [7:0]  cur_type;
  logic [23:0]  cur_size;
  logic [31:0]  cur_time;
  logic [23:0]  cur_stream;
  logic [31:0]  cur_word;
  logic  [7:0]  cur_media;
  logic [31:0]  file_offset;
  logic [23:0]  comp_raw;
  bit           sig_match;
  bit           parser_halted;

  // Forget any partial file or tag and wait for a new file header. The buffer limit and
  // the halt flag are not touched here.
  task automatic clear_parser();
    parse_phase = PS_HEADER;
    seg_count   = '0;
    fed_bytes   = '0;
    cur_type    = '0;
    cur_size    = '0;
    cur_time    = '0;
    cur_stream  = '0;
    cur_word    = '0;
    cur_media   = '0;
    file_offset = '0;
    comp_raw    = '0;
    sig_match   = 1'b1;
  endtask

  // A read segment may not end at or beyond the configured byte count.
  function automatic bit limit_reached(input logic [24:0] len);
    return ({1'b0, fed_bytes} + {8'd0, len}) >= {1'b0, byte_limit};
  endfunction

  // Advance the tracked parser by one input transaction and report the record, if any,
  // that the transaction must produce.
  task automatic parse_byte(input logic [7:0] b, input logic eos,
                            output bit emitted, output record_t rec);
    logic [23:0] idx;
    logic [24:0] seg_len;
    logic  [1:0] err_code;
    bit          err;
    bit          payload_over;
    emitted = 1'b0;
    rec = '0;
    err = 1'b0;
    err_code = ST_OK;
    payload_over = 1'b0;
    seg_len = '0;
    if (parser_halted) begin
      // A halted parser swallows everything, end markers included.
    end else if (eos) begin
      clear_parser();
      emitted = 1'b1;
      rec.record_kind = KIND_END;
      rec.status = ST_OK;
    end else begin
      // Fixed-length segments are checked against the limit on their first byte.
      if (seg_count == '0) begin
        case (parse_phase)
          PS_HEADER:     seg_len = LEN_HEADER;
          PS_TAG_HEADER: seg_len = LEN_TAGHDR;
          PS_PAYLOAD:    seg_len = '0;
          default:       seg_len = LEN_WORD;
        endcase
        if (seg_len != '0 && limit_reached(seg_len)) begin
          err = 1'b1;
          err_code = ST_LIMIT;
        end
      end
      if (!err) begin
        idx = seg_count;
        seg_count = seg_count + 24'd1;
        fed_bytes = fed_bytes + 32'd1;
        case (parse_phase)
          PS_HEADER: begin
            if (idx < 24'd3) begin
              if (b != FLV_MAGIC[8 * (2 - idx[1:0]) +: 8]) sig_match = 1'b0;
            end else if (idx == 24'd3) begin
              cur_type = b;
            end else if (idx == 24'd4) begin
              cur_media = b;
            end else begin
              file_offset = {file_offset[23:0], b};
            end
            // The signature verdict waits for the last header byte.
            if (idx == 24'd8) begin
              if (!sig_match) begin
                err = 1'b1;
                err_code = ST_SIGNATURE;
              end else begin
                parse_phase = PS_FIRST_WORD;
                seg_count = '0;
              end
            end
          end
          PS_FIRST_WORD: begin
            cur_word = {cur_word[23:0], b};
            if (idx == 24'd3) begin
              parse_phase = PS_TAG_HEADER;
              seg_count = '0;
              emitted = 1'b1;
              rec.record_kind = KIND_HEADER;
              rec.status = ST_OK;
              rec.tag_type = cur_type;
              rec.timestamp = file_offset;
              rec.prev_tag_size = cur_word;
              rec.media_high = cur_media[7:4];
              rec.media_low = cur_media[3:0];
            end
          end
          PS_TAG_HEADER: begin
            if (idx == 24'd0) begin
              cur_type = b;
              cur_media = '0;
              comp_raw = '0;
              cur_size = '0;
              cur_time = '0;
              cur_stream = '0;
            end else if (idx <= 24'd3) begin
              cur_size = {cur_size[15:0], b};
            end else if (idx <= 24'd6) begin
              cur_time = {8'd0, cur_time[15:0], b};
            end else if (idx == 24'd7) begin
              // The extension byte supplies the top eight bits of the timestamp.
              cur_time[31:24] = b;
            end else begin
              cur_stream = {cur_stream[15:0], b};
            end
            if (idx == 24'd10) begin
              if (limit_reached({1'b0, cur_size})) begin
                err = 1'b1;
                err_code = ST_LIMIT;
              end else begin
                seg_count = '0;
                if (cur_size == '0) payload_over = 1'b1;
                else parse_phase = PS_PAYLOAD;
              end
            end
          end
          PS_PAYLOAD: begin
            if (idx == 24'd0) cur_media = b;
            else if (idx >= 24'd2 && idx <= 24'd4) comp_raw = {comp_raw[15:0], b};
            if (({1'b0, idx} + 25'd1) >= {1'b0, cur_size}) begin
              // A short payload leaves the missing composition bytes at zero, so the
              // bytes that did arrive are moved up to their true positions.
              if (cur_size == 24'd3) comp_raw = {comp_raw[7:0], 16'd0};
              else if (cur_size == 24'd4) comp_raw = {comp_raw[15:0], 8'd0};
              payload_over = 1'b1;
            end
          end
          PS_TRAILER: begin
            cur_word = {cur_word[23:0], b};
            if (idx == 24'd3) begin
              parse_phase = PS_TAG_HEADER;
              seg_count = '0;
              emitted = 1'b1;
              rec.record_kind = KIND_TAG;
              rec.status = ST_OK;
              rec.tag_type = cur_type;
              rec.data_size = cur_size;
              rec.timestamp = cur_time;
              rec.stream_id = cur_stream;
              rec.prev_tag_size = cur_word;
              rec.media_high = cur_media[7:4];
              rec.media_low = cur_media[3:0];
              if (cur_type == TAG_VIDEO) begin
                rec.composition_time = comp_raw;
                rec.pts = cur_time + {{8{comp_raw[23]}}, comp_raw};
              end
            end
          end
          default: clear_parser();
        endcase
        // The tag type is judged only once the payload has been skipped.
        if (payload_over) begin
          if (cur_type != TAG_AUDIO && cur_type != TAG_VIDEO && cur_type != TAG_SCRIPT) begin
            err = 1'b1;
            err_code = ST_UNKNOWN;
          end else begin
            parse_phase = PS_TRAILER;
            seg_count = '0;
          end
        end
      end
      if (err) begin
        parser_halted = 1'b1;
        emitted = 1'b1;
        rec = '0;
        rec.record_kind = KIND_ERROR;
        rec.status = err_code;
      end
    end
  endtask

  // ---------------------------------------------------------------------------------
  // Stream construction. Bytes are staged per phase; a broken stream is cut short by
  // giving it only a limited number of bytes before its end marker.
  // ---------------------------------------------------------------------------------
  int unsigned stream_room;
  int unsigned stream_bytes;

  task automatic stage_byte(input logic [7:0] b);
    if (stream_room != 0) begin
      staged_items.insert(staged_items.size(), stream_item_t'({1'b0, b}));
      stream_room--;
      stream_bytes++;
    end
  endtask

  // Stage the low n bytes of a word, most significant first.
  task automatic stage_word(input logic [31:0] w, input int n);
    for (int i = n - 1; i >= 0; i--) stage_byte(w[8 * i +: 8]);
  endtask

  // The byte that rides along with an end marker is random, since the parser ignores it.
  task automatic stage_end();
    logic [7:0] filler;
    filler = 8'($urandom_range(0, 255));
    staged_items.insert(staged_items.size(), stream_item_t'({1'b1, filler}));
  endtask

  // Nine header bytes with the given signature, followed by the first size word.
  task automatic stage_file_header(input logic [23:0] magic);
    stage_word({8'd0, magic}, 3);
    stage_byte(8'($urandom_range(0, 255)));
    stage_byte(8'($urandom_range(0, 255)));
    stage_word($urandom, 4);
    stage_word($urandom, 4);
  endtask

  task automatic stage_tag_header(input logic [7:0] kind, input logic [23:0] size);
    logic [31:0] stamp;
    stamp = $urandom;
    stage_byte(kind);
    stage_word({8'd0, size}, 3);
    stage_word(stamp, 3);
    stage_byte(stamp[31:24]);
    stage_word($urandom, 3);
  endtask

  task automatic stage_tag(input logic [7:0] kind, input int unsigned size);
    stage_tag_header(kind, size[23:0]);
    repeat (size) stage_byte(8'($urandom_range(0, 255)));
    stage_word($urandom, 4);
  endtask

  // Video is favored because it carries the composition time and the pts sum.
  function automatic logic [7:0] pick_tag_type();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return TAG_VIDEO;
    else if (r < 8) return TAG_AUDIO;
    return TAG_SCRIPT;
  endfunction

  // Mostly tiny payloads, so that the empty and short composition cases come up often;
  // now and then a long one.
  function automatic int unsigned pick_payload_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 6);
    else if (r < 96) return $urandom_range(7, 40);
    return $urandom_range(100, 400);
  endfunction

  task automatic stage_stream(input bit broken);
    int n_tags;
    stream_bytes = 0;
    stream_room = broken ? $urandom_range(1, 80) : 32'hFFFF_FFFF;
    n_tags = $urandom_range(0, 8);
    stage_file_header(FLV_MAGIC);
    repeat (n_tags) stage_tag(pick_tag_type(), pick_payload_size());
    stage_end();
  endtask

  task automatic stage_random_streams(input int target);
    while (staged_items.size() < target) stage_stream($urandom_range(0, 5) == 0);
  endtask

  task automatic release_staged();
    while (staged_items.size() != 0) begin
      stream_items.insert(stream_items.size(), staged_items.pop_front());
    end
  endtask

  // Wait for the sender to run dry and for every owed record to arrive, then give the
  // pipeline time to finish any byte that produces no record.
  task automatic wait_idle();
    while (stream_items.size() != 0 || in_valid || records_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Registers are written only while the parser is idle, so the new limit applies from
  // the next accepted transaction on.
  task automatic write_limit(input logic [31:0] value);
    cfg_write_data <= value;
    cfg_write_en <= 1'b1;
    byte_limit = value;
    @(negedge clk);
    cfg_write_en <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------------
  // Sender. It works in bursts of random length separated by random gaps, and now and
  // then runs a long burst with no gap at all. Valid is held with a steady payload until
  // the transaction is taken.
  // ---------------------------------------------------------------------------------
  logic in_fire = 1'b0;
  int   burst_left = 0;
  int   gap_left = 0;

  always @(negedge clk) begin : sender
    stream_item_t item;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (stream_items.size() != 0) begin
        item = stream_items.pop_front();
        in_valid <= 1'b1;
        data_byte <= item.data;
        end_of_stream <= item.eos;
        if (burst_left != 0) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 24);
          gap_left = $urandom_range(1, 8);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------------
  // Receiver. Stretches of steady readiness alternate with choppy and mostly stalled
  // stretches, independent of the sender.
  // ---------------------------------------------------------------------------------
  int ready_mode = RX_OPEN;
  int ready_run = 0;

  always @(negedge clk) begin
    if (ready_run == 0) begin
      ready_mode = $urandom_range(RX_OPEN, RX_CHOKED);
      ready_run = $urandom_range(4, 60);
    end else begin
      ready_run--;
    end
    case (ready_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_CHOPPY: out_ready <= 1'($urandom_range(0, 1));
      default:   out_ready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  // ---------------------------------------------------------------------------------
  // Monitor. Everything is sampled at the rising edge. A delivered record is checked
  // against the oldest owed record before the input side adds new ones, so a record
  // that shows up with nothing owed is caught.
  // ---------------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] seen);
    if (seen !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, seen);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : monitor
    record_t got;
    record_t want;
    bit      emitted;
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        got = {record_kind, status, tag_type, data_size, timestamp, stream_id,
               prev_tag_size, media_high, media_low, composition_time, pts};
        if (records_due.size() == 0) begin
          $display("%0t: record kind %0d status %0d delivered with none expected",
                   $time, got.record_kind, got.status);
          mismatches++;
        end else begin
          want = records_due.pop_front();
          check_field("record_kind", 32'(want.record_kind), 32'(got.record_kind));
          check_field("status", 32'(want.status), 32'(got.status));
          check_field("tag_type", 32'(want.tag_type), 32'(got.tag_type));
          check_field("data_size", 32'(want.data_size), 32'(got.data_size));
          check_field("timestamp", want.timestamp, got.timestamp);
          check_field("stream_id", 32'(want.stream_id), 32'(got.stream_id));
          check_field("prev_tag_size", want.prev_tag_size, got.prev_tag_size);
          check_field("media_high", 32'(want.media_high), 32'(got.media_high));
          check_field("media_low", 32'(want.media_low), 32'(got.media_low));
          check_field("composition_time", 32'(want.composition_time),
                      32'(got.composition_time));
          check_field("pts", want.pts, got.pts);
        end
      end
      if (in_valid && in_ready) begin
        parse_byte(data_byte, end_of_stream, emitted, want);
        if (emitted) records_due.insert(records_due.size(), want);
      end
    end
  end

  // A hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == RUN_CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d records outstanding",
               $time, cycle_count, records_due.size());
      $display("flv_stream_tag_parser test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------
  // Stimulus. Four phases, each under its own buffer limit: the reset value, the
  // largest value, a limit just one byte above the longest stream, and a closing phase
  // that drives the parser into one error and then feeds it traffic it must ignore.
  // ---------------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned longest;
    int          closing_error;
    logic  [7:0] bad_byte;
    logic  [7:0] odd_type;
    int          bad_pos;

    byte_limit = LIMIT_RESET;
    parser_halted = 1'b0;
    clear_parser();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed stream: an end marker before any byte, a header with all-ones version,
    // flags and data offset and a zero first size word, then a video tag whose payload
    // holds only the first composition byte, which is negative. The end marker at the
    // close returns the parser to waiting for a header.
    stream_room = 32'hFFFF_FFFF;
    stage_end();
    stage_word({8'd0, FLV_MAGIC}, 3);
    stage_byte(8'hFF);
    stage_byte(8'hFF);
    stage_word(32'hFFFF_FFFF, 4);
    stage_word(32'h0000_0000, 4);
    stage_byte(TAG_VIDEO);
    stage_word(32'd3, 3);
    stage_word(32'h0000_0000, 4);
    stage_word(32'hFF_FFFF, 3);
    stage_byte(8'h17);
    stage_byte(8'h01);
    stage_byte(8'h80);
    stage_word(32'h0000_0012, 4);
    stage_end();

    // The rest of the first phase runs under the limit that reset loads.
    stage_random_streams(450);
    release_staged();
    wait_idle();

    write_limit(32'hFFFF_FFFF);
    stage_random_streams(450);
    release_staged();
    wait_idle();

    // The longest stream of this phase ends exactly one byte short of the limit.
    longest = 0;
    while (staged_items.size() < 350) begin
      stage_stream($urandom_range(0, 5) == 0);
      if (stream_bytes > longest) longest = stream_bytes;
    end
    write_limit(longest + 1);
    release_staged();
    wait_idle();

    // Closing phase: one error, chosen by the seed.
    closing_error = $urandom_range(FE_SIGNATURE, FE_OVERSIZE);
    stream_room = 32'hFFFF_FFFF;
    case (closing_error)
      FE_SIGNATURE: begin
        bad_pos = $urandom_range(0, 2);
        bad_byte = 8'($urandom_range(1, 255));
        write_limit(32'hFFFF_FFFF);
        stage_file_header(FLV_MAGIC ^ ({16'd0, bad_byte} << (8 * bad_pos)));
      end
      FE_TAG_TYPE: begin
        odd_type = 8'($urandom_range(0, 255));
        while (odd_type == TAG_AUDIO || odd_type == TAG_VIDEO || odd_type == TAG_SCRIPT) begin
          odd_type = 8'($urandom_range(0, 255));
        end
        write_limit(32'hFFFF_FFFF);
        stage_file_header(FLV_MAGIC);
        stage_tag(pick_tag_type(), pick_payload_size());
        stage_tag(odd_type, $urandom_range(0, 6));
      end
      FE_LIMIT_ZERO: begin
        write_limit(32'd0);
        stage_stream(1'b0);
      end
      FE_LIMIT_EDGE: begin
        // The last segment of this stream ends exactly at the limit.
        stage_stream(1'b0);
        write_limit(stream_bytes);
      end
      default: begin
        // A payload of the largest size cannot fit under the reset limit.
        write_limit(LIMIT_RESET);
        stage_file_header(FLV_MAGIC);
        stage_tag_header(pick_tag_type(), 24'hFF_FFFF);
      end
    endcase

    // Once halted, the parser must stay silent for bytes and end markers alike.
    stream_room = 32'hFFFF_FFFF;
    repeat (40) begin
      if ($urandom_range(0, 3) == 0) stage_end();
      else stage_byte(8'($urandom_range(0, 255)));
    end
    release_staged();
    wait_idle();

    if (mismatches == 0) begin
      $display("flv_stream_tag_parser test passed");
    end else begin
      $display("flv_stream_tag_parser test failed");
    end
    $finish;
  end

endmodule
